### design/tli_pkg.sv
// shared widths, payload structs and status codes for the two-line intersection block
`default_nettype none
package tli_pkg;

  // coordinate and result formats
  localparam int unsigned CoordBits   = 16;
  localparam int unsigned InFracBits  = CoordBits / 2;
  localparam int unsigned OutFracBits = 16;
  localparam int unsigned OutBits     = 32;

  // internal widths
  localparam int unsigned DeltaBits = CoordBits + 1;
  localparam int unsigned ProdBits  = 2 * DeltaBits;
  localparam int unsigned DetBits   = ProdBits + 1;
  localparam int unsigned NumBits   = DetBits + DeltaBits + 1;
  localparam int unsigned ShiftBits = OutFracBits - InFracBits;
  localparam int unsigned MagBits   = NumBits + ShiftBits;
  localparam int unsigned RemBits   = DetBits + OutBits;

  // status codes
  localparam logic [1:0] StFound    = 2'd0;
  localparam logic [1:0] StBothVert = 2'd1;
  localparam logic [1:0] StParallel = 2'd2;
  localparam logic [1:0] StSat      = 2'd3;

  typedef struct packed {
    logic signed [CoordBits-1:0] a_x1;
    logic signed [CoordBits-1:0] a_y1;
    logic signed [CoordBits-1:0] a_x2;
    logic signed [CoordBits-1:0] a_y2;
    logic signed [CoordBits-1:0] b_x1;
    logic signed [CoordBits-1:0] b_y1;
    logic signed [CoordBits-1:0] b_x2;
    logic signed [CoordBits-1:0] b_y2;
  } tli_in_t;

  typedef struct packed {
    logic signed [OutBits-1:0] cross_x;
    logic signed [OutBits-1:0] cross_y;
    logic [1:0]                status;
  } tli_out_t;

  // one coordinate inside the divider
  typedef struct packed {
    logic [RemBits-1:0] rem;
    logic [DetBits-1:0] den;
    logic [OutBits-1:0] quo;
    logic               neg;
    logic               sat;
  } tli_div_t;

endpackage
`default_nettype wire

### design/tli_div_step.sv
// one restoring division step, retires one quotient bit per stage
`default_nettype none
module tli_div_step #(
  parameter int unsigned BIT = 0
) (
  input  wire               clk_i,
  input  wire               en_i,
  input  tli_pkg::tli_div_t d_i,
  output tli_pkg::tli_div_t q_o
);
  import tli_pkg::*;

  logic [RemBits-1:0] shifted;
  logic [RemBits-1:0] diff;
  logic               take;
  tli_div_t           step_d;
  tli_div_t           step_q;

  // trial subtract of the divisor at this bit weight
  always_comb begin
    shifted = RemBits'(d_i.den) << BIT;
    diff    = d_i.rem - shifted;
    take    = (d_i.rem >= shifted);
    step_d  = d_i;
    if (take) begin
      step_d.rem      = diff;
      step_d.quo[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      step_q <= step_d;
    end
  end

  assign q_o = step_q;

endmodule
`default_nettype wire

### design/two_line_intersection.sv
// two-line intersection: fully pipelined determinant form with a bit-per-stage divider
//
// Input channel in_valid_i / in_stall_o carries one request of two lines, each
// given by two signed Q8.8 endpoints. Output channel out_valid_o / out_stall_i
// carries the crossing point in signed Q16.16, rounded toward zero, and status
// (found, both vertical, parallel, saturated).
// The pipeline has seven stages of deltas, products, determinants, numerator
// products, case selection, magnitudes and divider load, then 32 restoring
// divider stages (one quotient bit each, x and y side by side), then the output
// register.
// Throughput is one request per cycle while in_stall_o is low.
// Every stage has a valid bit and loads when it is empty or when the stages
// after it move. When the receiver stalls, results hold in the output register
// and requests keep entering until the pipeline has no empty stage left; only
// then is in_stall_o raised.
// Reset clears all valid bits; the data registers are not reset.
`default_nettype none
module two_line_intersection (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  tli_pkg::tli_in_t  in_data_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output tli_pkg::tli_out_t out_data_o
);
  import tli_pkg::*;

  localparam int unsigned PreStages = 7;
  localparam int unsigned NumStages = PreStages + OutBits + 1;

  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] en;

  // stage load enables: a stage moves if any stage at or after it is empty or the receiver does not stall
  for (genvar k = 0; k < NumStages; k++) begin : g_en
    assign en[k] = ~(&v_q[NumStages-1:k]) | ~out_stall_i;
  end

  assign in_stall_o = ~en[0];

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= (k == 0) ? in_valid_i : v_q[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  // stage 1: deltas and vertical flags
  logic signed [CoordBits-1:0] s1_xa1_q, s1_ya1_q, s1_xb1_q, s1_yb1_q;
  logic signed [DeltaBits-1:0] s1_dxa_q, s1_dya_q, s1_dxb_q, s1_dyb_q, s1_wx_q, s1_wy_q;
  logic                        s1_va_q, s1_vb_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_xa1_q <= in_data_i.a_x1;
      s1_ya1_q <= in_data_i.a_y1;
      s1_xb1_q <= in_data_i.b_x1;
      s1_yb1_q <= in_data_i.b_y1;
      s1_dxa_q <= DeltaBits'(in_data_i.a_x2) - DeltaBits'(in_data_i.a_x1);
      s1_dya_q <= DeltaBits'(in_data_i.a_y2) - DeltaBits'(in_data_i.a_y1);
      s1_dxb_q <= DeltaBits'(in_data_i.b_x2) - DeltaBits'(in_data_i.b_x1);
      s1_dyb_q <= DeltaBits'(in_data_i.b_y2) - DeltaBits'(in_data_i.b_y1);
      s1_wx_q  <= DeltaBits'(in_data_i.b_x1) - DeltaBits'(in_data_i.a_x1);
      s1_wy_q  <= DeltaBits'(in_data_i.b_y1) - DeltaBits'(in_data_i.a_y1);
      s1_va_q  <= (in_data_i.a_x2 == in_data_i.a_x1);
      s1_vb_q  <= (in_data_i.b_x2 == in_data_i.b_x1);
    end
  end

  // stage 2: first products
  logic signed [ProdBits-1:0]  s2_p1_q, s2_p2_q, s2_p3_q, s2_p4_q;
  logic signed [ProdBits-1:0]  s2_p5_q, s2_p6_q, s2_p7_q, s2_p8_q;
  logic signed [CoordBits-1:0] s2_xa1_q, s2_ya1_q, s2_xb1_q;
  logic signed [DeltaBits-1:0] s2_dxa_q, s2_dya_q, s2_dxb_q;
  logic                        s2_va_q, s2_vb_q;
  logic signed [ProdBits-1:0]  yb1_w, ya1_w;

  assign yb1_w = ProdBits'(s1_yb1_q);
  assign ya1_w = ProdBits'(s1_ya1_q);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_p1_q  <= s1_dxa_q * s1_dyb_q;
      s2_p2_q  <= s1_dya_q * s1_dxb_q;
      s2_p3_q  <= s1_wx_q * s1_dyb_q;
      s2_p4_q  <= s1_wy_q * s1_dxb_q;
      s2_p5_q  <= yb1_w * ProdBits'(s1_dxb_q);
      s2_p6_q  <= s1_dyb_q * s1_wx_q;
      s2_p7_q  <= ya1_w * ProdBits'(s1_dxa_q);
      s2_p8_q  <= s1_dya_q * s1_wx_q;
      s2_xa1_q <= s1_xa1_q;
      s2_ya1_q <= s1_ya1_q;
      s2_xb1_q <= s1_xb1_q;
      s2_dxa_q <= s1_dxa_q;
      s2_dya_q <= s1_dya_q;
      s2_dxb_q <= s1_dxb_q;
      s2_va_q  <= s1_va_q;
      s2_vb_q  <= s1_vb_q;
    end
  end

  // stage 3: determinant, cross term and vertical numerators
  logic signed [DetBits-1:0]   s3_det_q, s3_c_q, s3_nva_q, s3_nvb_q;
  logic signed [CoordBits-1:0] s3_xa1_q, s3_ya1_q, s3_xb1_q;
  logic signed [DeltaBits-1:0] s3_dxa_q, s3_dya_q, s3_dxb_q;
  logic                        s3_va_q, s3_vb_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_det_q <= DetBits'(s2_p1_q) - DetBits'(s2_p2_q);
      s3_c_q   <= DetBits'(s2_p3_q) - DetBits'(s2_p4_q);
      s3_nva_q <= DetBits'(s2_p5_q) - DetBits'(s2_p6_q);
      s3_nvb_q <= DetBits'(s2_p7_q) + DetBits'(s2_p8_q);
      s3_xa1_q <= s2_xa1_q;
      s3_ya1_q <= s2_ya1_q;
      s3_xb1_q <= s2_xb1_q;
      s3_dxa_q <= s2_dxa_q;
      s3_dya_q <= s2_dya_q;
      s3_dxb_q <= s2_dxb_q;
      s3_va_q  <= s2_va_q;
      s3_vb_q  <= s2_vb_q;
    end
  end

  // stage 4: numerator products of the general case
  logic signed [NumBits-1:0]   s4_m1_q, s4_m2_q, s4_m3_q, s4_m4_q;
  logic signed [DetBits-1:0]   s4_det_q, s4_nva_q, s4_nvb_q;
  logic signed [CoordBits-1:0] s4_xa1_q, s4_xb1_q;
  logic signed [DeltaBits-1:0] s4_dxa_q, s4_dxb_q;
  logic                        s4_va_q, s4_vb_q;
  logic signed [NumBits-1:0]   det_w, c_w;

  assign det_w = NumBits'(s3_det_q);
  assign c_w   = NumBits'(s3_c_q);

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_m1_q  <= NumBits'(s3_xa1_q) * det_w;
      s4_m2_q  <= NumBits'(s3_dxa_q) * c_w;
      s4_m3_q  <= NumBits'(s3_ya1_q) * det_w;
      s4_m4_q  <= NumBits'(s3_dya_q) * c_w;
      s4_det_q <= s3_det_q;
      s4_nva_q <= s3_nva_q;
      s4_nvb_q <= s3_nvb_q;
      s4_xa1_q <= s3_xa1_q;
      s4_xb1_q <= s3_xb1_q;
      s4_dxa_q <= s3_dxa_q;
      s4_dxb_q <= s3_dxb_q;
      s4_va_q  <= s3_va_q;
      s4_vb_q  <= s3_vb_q;
    end
  end

  // stage 5: pick numerators, denominators and status by case
  logic signed [NumBits-1:0] s5_nx_q, s5_ny_q, nx_d, ny_d;
  logic signed [DetBits-1:0] s5_dx_q, s5_dy_q, dx_d, dy_d;
  logic [1:0]                s5_st_q, st_d;
  logic signed [DetBits-1:0] one_w;

  assign one_w = DetBits'(1);

  always_comb begin
    nx_d = '0;
    ny_d = '0;
    dx_d = one_w;
    dy_d = one_w;
    st_d = StFound;
    priority if (s4_va_q && s4_vb_q) begin
      st_d = StBothVert;
    end else if (s4_va_q) begin
      nx_d = NumBits'(s4_xa1_q);
      ny_d = NumBits'(s4_nva_q);
      dy_d = DetBits'(s4_dxb_q);
    end else if (s4_vb_q) begin
      nx_d = NumBits'(s4_xb1_q);
      ny_d = NumBits'(s4_nvb_q);
      dy_d = DetBits'(s4_dxa_q);
    end else if (s4_det_q == '0) begin
      st_d = StParallel;
    end else begin
      nx_d = s4_m1_q + s4_m2_q;
      ny_d = s4_m3_q + s4_m4_q;
      dx_d = s4_det_q;
      dy_d = s4_det_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s5_nx_q <= nx_d;
      s5_ny_q <= ny_d;
      s5_dx_q <= dx_d;
      s5_dy_q <= dy_d;
      s5_st_q <= st_d;
    end
  end

  // stage 6: magnitudes, result sign and output scaling
  logic [MagBits-1:0] s6_mx_q, s6_my_q;
  logic [DetBits-1:0] s6_ax_q, s6_ay_q;
  logic               s6_negx_q, s6_negy_q;
  logic [1:0]         s6_st_q;
  logic [NumBits-1:0] absx, absy;

  assign absx = s5_nx_q[NumBits-1] ? NumBits'(-s5_nx_q) : NumBits'(s5_nx_q);
  assign absy = s5_ny_q[NumBits-1] ? NumBits'(-s5_ny_q) : NumBits'(s5_ny_q);

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s6_mx_q   <= MagBits'(absx) << ShiftBits;
      s6_my_q   <= MagBits'(absy) << ShiftBits;
      s6_ax_q   <= s5_dx_q[DetBits-1] ? DetBits'(-s5_dx_q) : DetBits'(s5_dx_q);
      s6_ay_q   <= s5_dy_q[DetBits-1] ? DetBits'(-s5_dy_q) : DetBits'(s5_dy_q);
      s6_negx_q <= (s5_nx_q[NumBits-1] ^ s5_dx_q[DetBits-1]) && (s5_nx_q != '0);
      s6_negy_q <= (s5_ny_q[NumBits-1] ^ s5_dy_q[DetBits-1]) && (s5_ny_q != '0);
      s6_st_q   <= s5_st_q;
    end
  end

  // stage 7: early overflow check, quotient of 2^32 or more, and divider load
  tli_div_t           divx [OutBits+1];
  tli_div_t           divy [OutBits+1];
  logic [1:0]         st_q [OutBits+1];
  tli_div_t           ldx, ldy;
  logic [RemBits-1:0] remx_w, remy_w;

  assign remx_w = RemBits'(s6_mx_q);
  assign remy_w = RemBits'(s6_my_q);

  always_comb begin
    ldx.rem = remx_w;
    ldx.den = s6_ax_q;
    ldx.quo = '0;
    ldx.neg = s6_negx_q;
    ldx.sat = (remx_w >= (RemBits'(s6_ax_q) << OutBits));
    ldy.rem = remy_w;
    ldy.den = s6_ay_q;
    ldy.quo = '0;
    ldy.neg = s6_negy_q;
    ldy.sat = (remy_w >= (RemBits'(s6_ay_q) << OutBits));
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      divx[0] <= ldx;
      divy[0] <= ldy;
      st_q[0] <= s6_st_q;
    end
  end

  // divider stages, most significant quotient bit first
  for (genvar j = 0; j < OutBits; j++) begin : g_div
    tli_div_step #(.BIT(OutBits - 1 - j)) u_stepx (
      .clk_i (clk_i),
      .en_i  (en[PreStages + j]),
      .d_i   (divx[j]),
      .q_o   (divx[j+1])
    );
    tli_div_step #(.BIT(OutBits - 1 - j)) u_stepy (
      .clk_i (clk_i),
      .en_i  (en[PreStages + j]),
      .d_i   (divy[j]),
      .q_o   (divy[j+1])
    );
    always_ff @(posedge clk_i) begin
      if (en[PreStages + j]) begin
        st_q[j+1] <= st_q[j];
      end
    end
  end

  // output stage: apply sign and saturate
  localparam logic [OutBits-1:0] MaxPos = {1'b0, {(OutBits-1){1'b1}}};
  localparam logic [OutBits-1:0] MinNeg = {1'b1, {(OutBits-1){1'b0}}};

  tli_div_t           fx, fy;
  logic [OutBits-1:0] rx, ry;
  logic               satx, saty;
  tli_out_t           out_d, out_q;

  assign fx = divx[OutBits];
  assign fy = divy[OutBits];

  always_comb begin
    if (fx.neg) begin
      satx = fx.sat || (fx.quo > MinNeg);
      rx   = satx ? MinNeg : OutBits'(-fx.quo);
    end else begin
      satx = fx.sat || (fx.quo > MaxPos);
      rx   = satx ? MaxPos : fx.quo;
    end
    if (fy.neg) begin
      saty = fy.sat || (fy.quo > MinNeg);
      ry   = saty ? MinNeg : OutBits'(-fy.quo);
    end else begin
      saty = fy.sat || (fy.quo > MaxPos);
      ry   = saty ? MaxPos : fy.quo;
    end
    out_d.cross_x = rx;
    out_d.cross_y = ry;
    out_d.status  = st_q[OutBits];
    if ((st_q[OutBits] == StFound) && (satx || saty)) begin
      out_d.status = StSat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NumStages-1]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v_q[NumStages-1];
  assign out_data_o  = out_q;

  // the input only stalls when the output holds a result the receiver refuses
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the output could move");

  // no intersection means zero coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == StBothVert || out_data_o.status == StParallel))
      |-> (out_data_o.cross_x == '0 && out_data_o.cross_y == '0))
    else $error("no-intersection result with nonzero coordinates");

  // a refused result stays in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

  // an accepted request reaches the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v_q[0])
    else $error("accepted request lost at entry");

endmodule
`default_nettype wire

### tb/tb_two_line_intersection.sv
// testbench for the two-line intersection block: directed, random and backpressure checks
`timescale 1ns / 1ps
`default_nettype none
module tb_two_line_intersection;
  import tli_pkg::*;

  localparam int unsigned HoldCycles = 300;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  tli_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  tli_out_t out_data_o;

  tli_out_t expected_crossings[$];
  int unsigned error_count = 0;
  int unsigned request_count = 0;
  int unsigned status_seen[4] = '{0, 0, 0, 0};
  int unsigned hold_request = 0;
  bit quiet_sender = 1'b0;
  bit quiet_receiver = 1'b0;

  two_line_intersection u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // scale a quotient to the output format, truncate toward zero and saturate
  function automatic logic [31:0] scaled_quotient(input logic signed [127:0] num,
                                                  input logic signed [127:0] den,
                                                  output logic sat);
    logic signed [127:0] q;
    q = (num <<< (OutFracBits - InFracBits)) / den;
    sat = 1'b0;
    if (q > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (q < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return q[31:0];
  endfunction

  // exact crossing point of the two lines
  function automatic tli_out_t predict_crossing(input tli_in_t r);
    logic signed [127:0] xa1, ya1, xa2, ya2, xb1, yb1, xb2, yb2;
    logic signed [127:0] dxa, dya, dxb, dyb, det, wx, wy, c;
    logic sat_x, sat_y;
    tli_out_t o;
    xa1 = $signed(r.a_x1); ya1 = $signed(r.a_y1);
    xa2 = $signed(r.a_x2); ya2 = $signed(r.a_y2);
    xb1 = $signed(r.b_x1); yb1 = $signed(r.b_y1);
    xb2 = $signed(r.b_x2); yb2 = $signed(r.b_y2);
    dxa = xa2 - xa1; dya = ya2 - ya1;
    dxb = xb2 - xb1; dyb = yb2 - yb1;
    o = '0;
    sat_x = 1'b0;
    sat_y = 1'b0;
    if (dxa == 0 && dxb == 0) begin
      o.status = StBothVert;
    end else if (dxa == 0) begin
      o.cross_x = scaled_quotient(xa1, 128'sd1, sat_x);
      o.cross_y = scaled_quotient(yb1 * dxb + dyb * (xa1 - xb1), dxb, sat_y);
    end else if (dxb == 0) begin
      o.cross_x = scaled_quotient(xb1, 128'sd1, sat_x);
      o.cross_y = scaled_quotient(ya1 * dxa + dya * (xb1 - xa1), dxa, sat_y);
    end else begin
      det = dxa * dyb - dya * dxb;
      if (det == 0) begin
        o.status = StParallel;
      end else begin
        wx = xb1 - xa1;
        wy = yb1 - ya1;
        c = wx * dyb - wy * dxb;
        o.cross_x = scaled_quotient(xa1 * det + dxa * c, det, sat_x);
        o.cross_y = scaled_quotient(ya1 * det + dya * c, det, sat_y);
      end
    end
    if (sat_x || sat_y) o.status = StSat;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic int unsigned idle_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // send one request and record its expected result when accepted
  task automatic send_request(input tli_in_t d);
    int unsigned gap;
    gap = quiet_sender ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do @(posedge clk_i); while (in_stall_o);
    expected_crossings.push_back(predict_crossing(d));
    request_count++;
  endtask

  task automatic finish_sending();
    in_valid_i <= 1'b0;
  endtask

  // receiver stall: random bursts, or a long hold when asked
  initial begin
    int unsigned n;
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        out_stall_i <= 1'b1;
        n = hold_request;
        repeat (n - 1) @(posedge clk_i);
        hold_request = 0;
      end else if (quiet_receiver) begin
        out_stall_i <= 1'b0;
      end else begin
        n = idle_gap();
        out_stall_i <= (n > 0);
        if (n > 1) repeat (n - 1) @(posedge clk_i);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    tli_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_crossings.size() == 0) begin
        report_mismatch("unexpected result cross_x", out_data_o.cross_x, 32'h0);
      end else begin
        want = expected_crossings.pop_front();
        if (out_data_o.cross_x !== want.cross_x)
          report_mismatch("cross_x", out_data_o.cross_x, want.cross_x);
        if (out_data_o.cross_y !== want.cross_y)
          report_mismatch("cross_y", out_data_o.cross_y, want.cross_y);
        if (out_data_o.status !== want.status)
          report_mismatch("status", 32'(out_data_o.status), 32'(want.status));
        status_seen[want.status]++;
      end
    end
  end

  function automatic logic signed [15:0] rnd_coord(input bit narrow);
    if (narrow) return 16'($signed($urandom_range(0, 4095)) - 2048);
    return 16'($urandom());
  endfunction

  // random line pair of a chosen geometric shape
  function automatic tli_in_t make_lines();
    tli_in_t d;
    int unsigned kind;
    logic signed [15:0] k;
    bit narrow;
    narrow = ($urandom_range(0, 1) == 1);
    d.a_x1 = rnd_coord(narrow); d.a_y1 = rnd_coord(narrow);
    d.a_x2 = rnd_coord(narrow); d.a_y2 = rnd_coord(narrow);
    d.b_x1 = rnd_coord(narrow); d.b_y1 = rnd_coord(narrow);
    d.b_x2 = rnd_coord(narrow); d.b_y2 = rnd_coord(narrow);
    kind = $urandom_range(0, 9);
    k = 16'($signed($urandom_range(0, 6)) - 3);
    case (kind)
      4: d.a_x2 = d.a_x1;
      5: d.b_x2 = d.b_x1;
      6: begin
        d.a_x2 = d.a_x1;
        d.b_x2 = d.b_x1;
      end
      7: begin
        // parallel: b direction is a multiple of a direction
        d.a_x2 = d.a_x1 + 16'($signed($urandom_range(0, 200)) - 100);
        d.a_y2 = d.a_y1 + 16'($signed($urandom_range(0, 200)) - 100);
        d.b_x2 = d.b_x1 + k * (d.a_x2 - d.a_x1);
        d.b_y2 = d.b_y1 + k * (d.a_y2 - d.a_y1);
      end
      8: begin
        // nearly parallel, far-away crossing
        d.a_x2 = d.a_x1 + 16'sd1000;
        d.a_y2 = d.a_y1 + 16'sd999;
        d.b_x2 = d.b_x1 + 16'sd1000;
        d.b_y2 = d.b_y1 + 16'($urandom_range(998, 1001));
      end
      default: ;
    endcase
    return d;
  endfunction

  function automatic tli_in_t lines(input int ax1, ay1, ax2, ay2, bx1, by1, bx2, by2);
    tli_in_t d;
    d.a_x1 = 16'(ax1); d.a_y1 = 16'(ay1); d.a_x2 = 16'(ax2); d.a_y2 = 16'(ay2);
    d.b_x1 = 16'(bx1); d.b_y1 = 16'(by1); d.b_x2 = 16'(bx2); d.b_y2 = 16'(by2);
    return d;
  endfunction

  // hand-picked geometry: each status and the coordinate extremes
  task automatic test_directed();
    send_request(lines(0, 0, 256, 256, 0, 256, 256, 0));
    send_request(lines(-256, 0, 256, 0, 0, -256, 0, 256));
    send_request(lines(100, 5, 100, 900, -300, 7, 400, 80));
    send_request(lines(-300, 7, 400, 80, -77, 5, -77, 900));
    send_request(lines(5, 1, 5, 2, -9, 3, -9, 4));
    send_request(lines(7, 7, 7, 7, 3, 3, 3, 3));
    send_request(lines(7, 7, 7, 7, 0, 0, 10, 10));
    send_request(lines(0, 0, 10, 20, 5, 0, 15, 20));
    send_request(lines(0, 0, 10, 20, 20, 40, 30, 60));
    send_request(lines(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_request(lines(32767, 32767, -32768, -32768, 0, 0, 1, 0));
    send_request(lines(-32768, 0, -32768, 1, 32767, -32768, -32767, 32767));
    send_request(lines(0, 0, 32767, 32766, 0, 1, 32767, 32767));
    send_request(lines(-32768, 32767, 32767, 32766, 32767, -32768, -32768, -32767));
    send_request(lines(0, 0, 1, 0, 0, 1, 1, 1));
    send_request(lines(-1, -1, 1, 1, 1, -1, -1, 1));
    send_request(lines(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_request(lines(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_request(lines(-1, -1, -1, -1, -1, -1, -1, -1));
    send_request(lines(0, -32768, 1, 32767, 0, 32767, 1, -32768));
    finish_sending();
  endtask

  // long random run, alternating idle and busy stretches
  task automatic test_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 200 == 0) begin
        quiet_sender = ($urandom_range(0, 3) == 0);
        quiet_receiver = ($urandom_range(0, 3) == 0);
      end
      send_request(make_lines());
    end
    quiet_sender = 1'b0;
    quiet_receiver = 1'b0;
    finish_sending();
  endtask

  // receiver holds off while the sender keeps offering requests
  task automatic test_backpressure();
    quiet_sender = 1'b1;
    hold_request = HoldCycles;
    for (int unsigned i = 0; i < 80; i++) send_request(make_lines());
    quiet_sender = 1'b0;
    finish_sending();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(1800);
    while (expected_crossings.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("%0d requests: %0d found, %0d both vertical, %0d parallel, %0d saturated",
             request_count, status_seen[StFound], status_seen[StBothVert],
             status_seen[StParallel], status_seen[StSat]);
    $display("random idling on both sides plus one %0d-cycle receiver hold-off",
             HoldCycles);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", expected_crossings.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire

### files.f
design/tli_pkg.sv
design/tli_div_step.sv
design/two_line_intersection.sv
tb/tb_two_line_intersection.sv
